@@ rtl/lrufr_pkg.sv @@
package lrufr_pkg;

   localparam int MODE_W     = 2;
   localparam int FRAME_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // request opcodes
   localparam logic [MODE_W-1:0] MODE_UNPIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PIN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EVICT = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   // register index, taken from paddr above the byte lanes
   localparam logic CSR_REG_CAPACITY = 1'b0;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] frame_num;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [FRAME_W-1:0]  victim_frame;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  tracked_count;
   } rsp_type;

endpackage

@@ rtl/lru_frame_replacer.sv @@
// LRU frame replacer: keeps the evictable buffer frames in the order they
// were unpinned, as a doubly linked list in two link RAMs (older / newer).
// Request channel (req_valid / req_stall / req_payload): mode unpin, pin or
// evict plus a frame id. Response channel (rsp_valid / rsp_stall /
// rsp_payload): ok, victim frame, status and the tracked count after the op.
// Exactly one response per request, in request order.
// Timing: a request is taken while the block is idle; the link RAMs are read
// at the accept edge and the list is updated in the execute state that
// follows, which also loads the response register. rsp_valid rises once the
// execute step is done, and no new request is taken before then; the read
// of the link RAMs must come before the read-modify-write.
// A held response does not block the next accept; only the execute step
// waits while rsp_valid is high and rsp_stall holds it.
// Reset (synchronous): list empty, count zero, capacity 64, no response
// pending. Link RAM contents are not cleared; entries are written before
// they are read. The capacity register sits at APB address 0; write it
// only while the block is idle.
module lru_frame_replacer #(
   parameter int NUM_FRAMES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lrufr_pkg::req_type                   req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lrufr_pkg::rsp_type                   rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lrufr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lrufr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lrufr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);

   import lrufr_pkg::*;

   // frame ids are 6 bits, so at most 64 frames can ever be tracked
   localparam int LINK_DEPTH = (NUM_FRAMES < (1 << FRAME_W)) ? NUM_FRAMES : (1 << FRAME_W);
   localparam int LINK_W     = $clog2(LINK_DEPTH);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff;
   logic [MODE_W-1:0]     op_mode_ff;
   logic [LINK_W-1:0]     op_slot_ff;
   logic                  op_in_range_ff;
   logic [LINK_DEPTH-1:0] present_ff, present_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [LINK_W-1:0]     oldest_ff, oldest_in;
   logic [LINK_W-1:0]     newest_ff, newest_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff, rsp_in;
   logic [COUNT_W-1:0]    capacity_ff;

   logic                  req_fire;
   logic                  req_in_range;
   logic [LINK_W-1:0]     req_slot;
   logic [LINK_W-1:0]     rd_addr;
   logic                  exec_go;

   logic                  older_we, newer_we;
   logic [LINK_W-1:0]     older_wa, newer_wa;
   logic [LINK_W-1:0]     older_wd, newer_wd;
   logic [LINK_W-1:0]     older_rd, newer_rd;

   logic                  do_link, do_unlink;
   logic [LINK_W-1:0]     unlink_slot;

   // ---------------- config port ----------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1] == CSR_REG_CAPACITY) begin
         capacity_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_REG_CAPACITY) ?
                   CSR_DATA_W'(capacity_ff) : '0;

   // ---------------- request side ----------------
   assign req_stall    = (state_ff != S_IDLE);
   assign req_fire     = req_valid && !req_stall;
   assign req_in_range = 32'(req_payload.frame_num) < 32'(LINK_DEPTH);
   assign req_slot     = LINK_W'(req_payload.frame_num);
   // evict unlinks the oldest frame, so its links are what we fetch
   assign rd_addr      = (req_payload.mode == MODE_EVICT) ? oldest_ff : req_slot;

   // execute only once the response register is free or draining
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   lrufr_link_ram #(.DEPTH(LINK_DEPTH), .WIDTH(LINK_W)) u_older_ram (
      .clock   (clock),
      .wr_en   (older_we),
      .wr_addr (older_wa),
      .wr_data (older_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   lrufr_link_ram #(.DEPTH(LINK_DEPTH), .WIDTH(LINK_W)) u_newer_ram (
      .clock   (clock),
      .wr_en   (newer_we),
      .wr_addr (newer_wa),
      .wr_data (newer_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   // ---------------- execute: decide, relink, build response ----------------
   assign unlink_slot = (op_mode_ff == MODE_EVICT) ? oldest_ff : op_slot_ff;

   always_comb begin
      do_link   = 1'b0;
      do_unlink = 1'b0;
      rsp_in    = '0;
      rsp_in.status = STATUS_DONE;

      case (op_mode_ff)
         MODE_UNPIN: begin
            if (op_in_range_ff && present_ff[op_slot_ff]) begin
               rsp_in.ok = 1'b1;             // already tracked: no move
            end else if (op_in_range_ff && count_ff < capacity_ff) begin
               do_link   = 1'b1;
               rsp_in.ok = 1'b1;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         MODE_PIN: begin
            if (op_in_range_ff && present_ff[op_slot_ff]) begin
               do_unlink = 1'b1;
               rsp_in.ok = 1'b1;
            end else begin
               rsp_in.status = STATUS_ABSENT;
            end
         end
         MODE_EVICT: begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               do_unlink           = 1'b1;
               rsp_in.ok           = 1'b1;
               rsp_in.victim_frame = FRAME_W'(oldest_ff);
            end
         end
         default: begin
            // unused opcode: no change, ok low
         end
      endcase
   end

   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      older_we   = 1'b0;
      older_wa   = '0;
      older_wd   = '0;
      newer_we   = 1'b0;
      newer_wa   = '0;
      newer_wd   = '0;

      if (do_link) begin
         if (count_ff == '0) begin
            oldest_in = op_slot_ff;
         end else begin
            older_we = exec_go;
            older_wa = op_slot_ff;
            older_wd = newest_ff;
            newer_we = exec_go;
            newer_wa = newest_ff;
            newer_wd = op_slot_ff;
         end
         newest_in              = op_slot_ff;
         present_in[op_slot_ff] = 1'b1;
         count_in               = count_ff + 7'd1;
      end else if (do_unlink) begin
         if (count_ff > 7'd1) begin
            if (unlink_slot == oldest_ff) begin
               oldest_in = newer_rd;
            end else if (unlink_slot == newest_ff) begin
               newest_in = older_rd;
            end else begin
               // middle of the list: splice the neighbors together
               newer_we = exec_go;
               newer_wa = older_rd;
               newer_wd = newer_rd;
               older_we = exec_go;
               older_wa = newer_rd;
               older_wd = older_rd;
            end
         end
         present_in[unlink_slot] = 1'b0;
         count_in                = count_ff - 7'd1;
      end
   end

   // ---------------- sequencer and state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_payload_ff <= '0;
         present_ff     <= '0;
         count_ff       <= '0;
         oldest_ff      <= '0;
         newest_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  state_ff       <= S_IDLE;
                  present_ff     <= present_in;
                  count_ff       <= count_in;
                  oldest_ff      <= oldest_in;
                  newest_ff      <= newest_in;
                  rsp_payload_ff <= '{ok:            rsp_in.ok,
                                       victim_frame:  rsp_in.victim_frame,
                                       status:        rsp_in.status,
                                       tracked_count: count_in};
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_mode_ff     <= req_payload.mode;
         op_slot_ff     <= req_slot;
         op_in_range_ff <= req_in_range;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(LINK_DEPTH))
      else $error("tracked count above frame count");

   a_count_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == 32'(count_ff))
      else $error("tracked count disagrees with present bits");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EXEC)
      else $error("accepted request did not enter execute");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("execute step did not load a response");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.ok |-> rsp_payload_ff.status == STATUS_DONE)
      else $error("ok response carries an error status");
`endif

endmodule

@@ rtl/lrufr_link_ram.sv @@
module lrufr_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ test/lru_frame_replacer_checker.sv @@
`timescale 1ns / 1ps

// Passive scoreboard: mirrors the replacer's list, predicts one response per
// accepted request and compares accepted responses in order.
module lru_frame_replacer_checker #(
   parameter int NUM_FRAMES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  lrufr_pkg::req_type               req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  lrufr_pkg::rsp_type               rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lrufr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lrufr_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                             pready,
   output int                               mismatch_count,
   output int                               pending_count
);

   import lrufr_pkg::*;

   // shadow list state
   logic               tracked  [NUM_FRAMES];
   logic [FRAME_W-1:0] older_of [NUM_FRAMES];
   logic [FRAME_W-1:0] newer_of [NUM_FRAMES];
   logic [FRAME_W-1:0] head_new;
   logic [FRAME_W-1:0] head_old;
   logic [COUNT_W-1:0] live_count;
   logic [COUNT_W-1:0] capacity_q;

   rsp_type expected_rsp[$];

   function automatic void drop_frame(logic [FRAME_W-1:0] f);
      logic [FRAME_W-1:0] o;
      logic [FRAME_W-1:0] n;
      o = older_of[f];
      n = newer_of[f];
      if (live_count > 1) begin
         if (f == head_old) begin
            head_old = n;
         end else if (f == head_new) begin
            head_new = o;
         end else begin
            newer_of[o] = n;
            older_of[n] = o;
         end
      end
      tracked[f] = 1'b0;
      if (live_count > 0) live_count--;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type res;
      logic    in_range;
      logic    hit;
      res      = '0;
      in_range = int'(r.frame_num) < NUM_FRAMES;
      hit      = in_range && tracked[r.frame_num];
      case (r.mode)
         MODE_UNPIN: begin
            if (hit) begin
               res.ok = 1'b1;
            end else if (in_range && live_count < capacity_q) begin
               if (live_count == 0) begin
                  head_new = r.frame_num;
                  head_old = r.frame_num;
               end else begin
                  older_of[r.frame_num] = head_new;
                  newer_of[head_new]    = r.frame_num;
                  head_new              = r.frame_num;
               end
               tracked[r.frame_num] = 1'b1;
               live_count++;
               res.ok = 1'b1;
            end else begin
               res.status = STATUS_FULL;
            end
         end
         MODE_PIN: begin
            if (hit) begin
               drop_frame(r.frame_num);
               res.ok = 1'b1;
            end else begin
               res.status = STATUS_ABSENT;
            end
         end
         MODE_EVICT: begin
            if (live_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.victim_frame = head_old;
               drop_frame(head_old);
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.tracked_count = live_count;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) tracked[i] = 1'b0;
         head_new       = '0;
         head_old       = '0;
         live_count     = '0;
         capacity_q     = CAPACITY_RESET;
         mismatch_count = 0;
         expected_rsp.delete();
      end else begin
         // response side first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: %p", rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload !== want) begin
                  if (mismatch_count < 10)
                     $display({"mismatch: expected ok %0d victim %0d status %0d count %0d,",
                               " got ok %0d victim %0d status %0d count %0d"},
                              want.ok, want.victim_frame, want.status, want.tracked_count,
                              rsp_payload.ok, rsp_payload.victim_frame,
                              rsp_payload.status, rsp_payload.tracked_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(predict_response(req_payload));
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == CSR_REG_CAPACITY)
            capacity_q = pwdata[COUNT_W-1:0];
      end
      pending_count = expected_rsp.size();
   end

endmodule

@@ test/tb_lru_frame_replacer.sv @@
`timescale 1ns / 1ps

module tb_lru_frame_replacer;
   import lrufr_pkg::*;

   // spare opcode, must leave the list untouched
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 228;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    pending_count;

   // per-phase knobs: capacity (-1 = random), idle style, share of unpins
   int phase_cap   [PHASES] = '{64, 127, 0, 1, 5, 65, -1, 64};
   int phase_idle  [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
   int phase_unpin [PHASES] = '{70, 70, 45, 45, 50, 55, 50, 45};

   int gap_pct   = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;   // chance per cycle that the receiver stalls

   // frames recently unpinned, so that pins mostly hit tracked frames
   logic [FRAME_W-1:0] recent_unpins[$];

   int                 pick;
   int                 pin_limit;
   logic [MODE_W-1:0]  mode;
   logic [FRAME_W-1:0] fid;

   lru_frame_replacer dut (.*);
   lru_frame_replacer_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure, redrawn every cycle
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // Present one request and hold it until it is taken. Returns at the
   // falling edge after acceptance with valid still high, so back-to-back
   // requests keep valid asserted without a glitch.
   task automatic send_request(input logic [MODE_W-1:0] m, input logic [FRAME_W-1:0] f);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < gap_pct) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{mode: m, frame_num: f};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Capacity is only changed with the block idle: drain all responses,
   // give the pipeline a few spare cycles, then do one APB write.
   task automatic write_capacity(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4) @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {CSR_REG_CAPACITY, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed: reset capacity of 64 ----
      send_request(MODE_EVICT, 6'd0);      // empty list
      send_request(MODE_PIN, 6'd0);        // pin of absent frame
      send_request(MODE_RESERVED, 6'd63);  // spare opcode, no effect
      send_request(MODE_UNPIN, 6'd0);
      send_request(MODE_UNPIN, 6'd63);
      send_request(MODE_UNPIN, 6'd0);      // already tracked, stays put
      send_request(MODE_UNPIN, 6'd21);
      send_request(MODE_UNPIN, 6'd42);
      send_request(MODE_PIN, 6'd21);       // unlink from the middle
      send_request(MODE_PIN, 6'd42);       // unlink the newest
      send_request(MODE_PIN, 6'd0);        // unlink the oldest
      send_request(MODE_EVICT, 6'd17);     // last one left: 63
      send_request(MODE_EVICT, 6'd0);
      send_request(MODE_UNPIN, 6'd5);
      send_request(MODE_PIN, 6'd5);        // sole entry
      send_request(MODE_UNPIN, 6'd7);
      send_request(MODE_EVICT, 6'd0);

      // zero capacity: every new unpin is full
      write_capacity(7'd0);
      send_request(MODE_UNPIN, 6'd3);
      send_request(MODE_PIN, 6'd3);

      // capacity of one
      write_capacity(7'd1);
      send_request(MODE_UNPIN, 6'd1);
      send_request(MODE_UNPIN, 6'd2);      // full
      send_request(MODE_UNPIN, 6'd1);      // tracked, still ok while full
      send_request(MODE_EVICT, 6'd0);

      // ---- random phases ----
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_cap[p] < 0 ? COUNT_W'($urandom_range(127))
                                         : COUNT_W'(phase_cap[p]));
         case (phase_idle[p])
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 81; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 81; end
            default: begin gap_pct = 30; stall_pct = 30; end
         endcase
         pin_limit = phase_unpin[p] + (97 - phase_unpin[p]) * 6 / 10;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            fid  = FRAME_W'($urandom_range(63));
            if (pick < phase_unpin[p]) begin
               mode = MODE_UNPIN;
               // half the unpins from a narrow window, to repeat frames
               if ($urandom_range(1) == 0) fid = FRAME_W'($urandom_range(15));
               recent_unpins.push_back(fid);
               if (recent_unpins.size() > 16) void'(recent_unpins.pop_front());
            end else if (pick < pin_limit) begin
               mode = MODE_PIN;
               if (recent_unpins.size() > 0 && $urandom_range(9) < 7)
                  fid = recent_unpins[$urandom_range(recent_unpins.size() - 1)];
            end else if (pick < 97) begin
               mode = MODE_EVICT;
            end else begin
               mode = MODE_RESERVED;
            end
            send_request(mode, fid);
         end
      end

      // drain, then a little slack for anything still in flight
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lrufr_pkg.sv
rtl/lrufr_link_ram.sv
rtl/lru_frame_replacer.sv
test/lru_frame_replacer_checker.sv
test/tb_lru_frame_replacer.sv
